// ----- design/best_fit_block_allocator_unit_assert.svh -----
// Assertion macros for the best-fit block allocator unit
`ifndef BEST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, switched off while reset is asserted
`define BFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also runs through reset
`define BFA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFA_ASSERT(lbl, prop, msg)
`define BFA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- design/bfa_pkg.sv -----
// Shared types and constants of the best-fit block allocator
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int ADDR_BITS  = 24;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SIZE_W     = 24;
  localparam int HDR_W      = 13;
  localparam int PAGE_W     = 17;
  localparam int LIMIT_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  // 2*header + size
  localparam int DVD_W      = SIZE_W + 1;
  localparam int DIV_CNT_W  = $clog2(DVD_W) + 1;
  // (quotient + 1) * page
  localparam int GROW_W     = DVD_W + 1 + PAGE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OUT_HEAP  = 2'd1;
  localparam logic [1:0] ST_TBL_FULL  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] req_size;
    logic [23:0]       free_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] data_addr;
  } res_t;

  // one block table entry
  typedef struct packed {
    logic                 valid;
    logic                 busy;
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_W-1:0]    size;
  } entry_t;

endpackage

// ----- design/bfa_cell.sv -----
// One table cell of the rotating block chain
`timescale 1ns / 1ps
module bfa_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  bfa_pkg::entry_t d,
  output bfa_pkg::entry_t q
);
  import bfa_pkg::*;

  logic                 valid_r;
  logic                 busy_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [SIZE_W-1:0]    size_r;

  // valid bit clears on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= d.valid;
    end
  end

  // take the neighbor's entry on each shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      busy_r <= d.busy;
      addr_r <= d.addr;
      size_r <= d.size;
    end
  end

  assign q = '{valid: valid_r, busy: busy_r, addr: addr_r, size: size_r};

endmodule

// ----- design/bfa_div.sv -----
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bfa_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bfa_pkg::DVD_W-1:0]  dividend,
  input  logic [bfa_pkg::PAGE_W-1:0] divisor,
  output logic                      done,
  output logic [bfa_pkg::DVD_W-1:0]  quotient
);
  import bfa_pkg::*;

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [PAGE_W-1:0]    rem_r;
  logic [PAGE_W-1:0]    dsr_r;
  logic [DVD_W-1:0]     quo_r;
  logic [PAGE_W:0]      shifted;
  logic                 fits;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dsr_r};

  // control: count the steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath: shift in one dividend bit, subtract where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      dsr_r <= divisor;
      quo_r <= dividend;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (fits) begin
        rem_r <= PAGE_W'(shifted - {1'b0, dsr_r});
      end else begin
        rem_r <= shifted[PAGE_W-1:0];
      end
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- design/best_fit_block_allocator_unit.sv -----
// Top level of the best-fit block allocator: sequencer, cell chain, registers
`timescale 1ns / 1ps
`include "best_fit_block_allocator_unit_assert.svh"
// The block table lives in a ring of MAX_BLOCKS cells that, while a scan runs,
// rotates one entry per cycle past a single compare unit at its head. A request is
// taken when start is high and busy is low, and its one result appears on out_res
// for exactly one cycle with out_valid high; the receiver cannot stall it. A free
// request, or an allocate that hits an exact-size block, takes one full rotation.
// An allocate that splits an existing block takes two rotations plus the decide
// and split states. An allocate that grows the heap adds the page divider, one
// quotient bit per cycle, and a multiply and a check. Errors end after the first
// rotation or after the heap check. Configuration is to be written through cfg_*
// only while busy is low; the block itself does not enforce this.
module best_fit_block_allocator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  bfa_pkg::req_t                  in_req,
  output logic                           out_valid,
  output bfa_pkg::res_t                  out_res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN1, S_DECIDE, S_DIV, S_MUL, S_CHK, S_SPLIT, S_SCAN2
  } state_t;

  // configuration registers
  logic [HDR_W-1:0]   header_r;
  logic [PAGE_W-1:0]  page_r;
  logic [LIMIT_W-1:0] limit_r;

  assign cfg_ready = 1'b1;

  // take a configuration transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HDR_W'(32);
      page_r   <= PAGE_W'(4096);
      limit_r  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEADER: header_r <= cfg_wdata[HDR_W-1:0];
        CFG_PAGE:   page_r   <= PAGE_W'(cfg_wdata);
        CFG_LIMIT:  limit_r  <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer registers
  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  res_r, res_nxt;
  req_t                  req_r, req_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  hit_r, hit_nxt;
  logic                  best_found_r, best_found_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [ADDR_BITS-1:0]  best_addr_r, best_addr_nxt;
  logic [SIZE_W-1:0]     best_size_r, best_size_nxt;
  logic [IDX_W-1:0]      tgt_idx_r, tgt_idx_nxt;
  logic [ADDR_BITS-1:0]  tgt_addr_r, tgt_addr_nxt;
  logic [SIZE_W-1:0]     tgt_size_r, tgt_size_nxt;
  entry_t                carry_r, carry_nxt;
  logic [GROW_W-1:0]     grow_r, grow_nxt;
  logic [ADDR_BITS-1:0]  heap_end_r, heap_end_nxt;

  // cell chain
  entry_t cell_q [MAX_BLOCKS];
  entry_t cell_d [MAX_BLOCKS];
  entry_t head;
  entry_t tail;
  logic   shift_en;

  assign head     = cell_q[0];
  assign shift_en = (state_r == S_SCAN1) || (state_r == S_SCAN2);

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    if (g == MAX_BLOCKS - 1) begin : g_tail
      assign cell_d[g] = tail;
    end else begin : g_link
      assign cell_d[g] = cell_q[g+1];
    end
    bfa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d        (cell_d[g]),
      .q        (cell_q[g])
    );
  end

  // growth arithmetic
  logic [PAGE_W-1:0]    pg_eff;
  logic [DVD_W-1:0]     dividend;
  logic                 div_start;
  logic                 div_done;
  logic [DVD_W-1:0]     quo;
  logic [DVD_W:0]       quo_inc;
  logic [GROW_W-1:0]    grow_prod;
  logic [GROW_W:0]      new_end;
  logic [SIZE_W:0]      need;
  logic                 idx_last;

  assign pg_eff    = (page_r == '0) ? PAGE_W'(1) : page_r;
  assign dividend  = DVD_W'({header_r, 1'b0}) + DVD_W'(req_r.req_size);
  assign quo_inc   = {1'b0, quo} + 1'b1;
  assign grow_prod = quo_inc * pg_eff;
  assign new_end   = {1'b0, GROW_W'(heap_end_r)} + {1'b0, grow_r};
  assign need      = {1'b0, req_r.req_size} + (SIZE_W + 1)'(header_r);
  assign idx_last  = idx_r == IDX_W'(MAX_BLOCKS - 1);

  bfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (pg_eff),
    .done     (div_done),
    .quotient (quo)
  );

  // next-state and datapath decisions
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    res_nxt        = res_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    hit_nxt        = hit_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_addr_nxt  = best_addr_r;
    best_size_nxt  = best_size_r;
    tgt_idx_nxt    = tgt_idx_r;
    tgt_addr_nxt   = tgt_addr_r;
    tgt_size_nxt   = tgt_size_r;
    carry_nxt      = carry_r;
    grow_nxt       = grow_r;
    heap_end_nxt   = heap_end_r;
    tail           = head;
    div_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt        = in_req;
          idx_nxt        = '0;
          cnt_nxt        = '0;
          hit_nxt        = 1'b0;
          best_found_nxt = 1'b0;
          state_nxt      = S_SCAN1;
        end
      end

      // first rotation: search, count, and mark a free or exact hit in place
      S_SCAN1: begin
        idx_nxt = idx_r + 1'b1;
        if (head.valid) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (req_r.req_type == REQ_FREE) begin
          if (head.valid && !hit_r && head.addr == ADDR_BITS'(req_r.free_addr)) begin
            tail.busy = 1'b0;
            hit_nxt   = 1'b1;
          end
        end else if (head.valid && !head.busy && !hit_r) begin
          if (head.size == req_r.req_size) begin
            tail.busy    = 1'b1;
            hit_nxt      = 1'b1;
            tgt_addr_nxt = head.addr;
          end else if (need < {1'b0, head.size} &&
                       (!best_found_r || head.size < best_size_r)) begin
            best_found_nxt = 1'b1;
            best_idx_nxt   = idx_r;
            best_addr_nxt  = head.addr;
            best_size_nxt  = head.size;
          end
        end
        if (idx_last) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (req_r.req_type == REQ_FREE) begin
          out_valid_nxt     = 1'b1;
          res_nxt.status    = hit_r ? ST_OK : ST_NOT_FOUND;
          res_nxt.data_addr = '0;
          state_nxt         = S_IDLE;
        end else if (hit_r) begin
          out_valid_nxt     = 1'b1;
          res_nxt.status    = ST_OK;
          res_nxt.data_addr = 24'(tgt_addr_r);
          state_nxt         = S_IDLE;
        end else if (best_found_r) begin
          if (cnt_r == CNT_W'(MAX_BLOCKS)) begin
            out_valid_nxt     = 1'b1;
            res_nxt.status    = ST_TBL_FULL;
            res_nxt.data_addr = '0;
            state_nxt         = S_IDLE;
          end else begin
            tgt_idx_nxt  = best_idx_r;
            tgt_addr_nxt = best_addr_r;
            tgt_size_nxt = best_size_r;
            state_nxt    = S_SPLIT;
          end
        end else if (cnt_r > CNT_W'(MAX_BLOCKS - 2)) begin
          out_valid_nxt     = 1'b1;
          res_nxt.status    = ST_TBL_FULL;
          res_nxt.data_addr = '0;
          state_nxt         = S_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        grow_nxt  = grow_prod;
        state_nxt = S_CHK;
      end

      // check the limit, then place the new block at the end of the table
      S_CHK: begin
        if (new_end > (GROW_W + 1)'(limit_r) ||
            new_end > (GROW_W + 1)'({ADDR_BITS{1'b1}})) begin
          out_valid_nxt     = 1'b1;
          res_nxt.status    = ST_OUT_HEAP;
          res_nxt.data_addr = '0;
          state_nxt         = S_IDLE;
        end else begin
          tgt_idx_nxt  = cnt_r[IDX_W-1:0];
          tgt_addr_nxt = heap_end_r + ADDR_BITS'(header_r);
          tgt_size_nxt = SIZE_W'(grow_r - GROW_W'(header_r));
          heap_end_nxt = new_end[ADDR_BITS-1:0];
          state_nxt    = S_SPLIT;
        end
      end

      // build the remainder entry
      S_SPLIT: begin
        carry_nxt.valid = 1'b1;
        carry_nxt.busy  = 1'b0;
        carry_nxt.addr  = tgt_addr_r + ADDR_BITS'(req_r.req_size) +
                          ADDR_BITS'(header_r);
        carry_nxt.size  = tgt_size_r - req_r.req_size - SIZE_W'(header_r);
        idx_nxt         = '0;
        state_nxt       = S_SCAN2;
      end

      // second rotation: rewrite the target and shift later entries down by one
      S_SCAN2: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == tgt_idx_r) begin
          tail.valid = 1'b1;
          tail.busy  = 1'b1;
          tail.addr  = tgt_addr_r;
          tail.size  = req_r.req_size;
        end else if (idx_r > tgt_idx_r) begin
          tail      = carry_r;
          carry_nxt = head;
        end
        if (idx_last) begin
          out_valid_nxt     = 1'b1;
          res_nxt.status    = ST_OK;
          res_nxt.data_addr = 24'(tgt_addr_r);
          state_nxt         = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      heap_end_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      heap_end_r   <= heap_end_nxt;
      res_r        <= res_nxt;
      req_r        <= req_nxt;
      idx_r        <= idx_nxt;
      cnt_r        <= cnt_nxt;
      hit_r        <= hit_nxt;
      best_found_r <= best_found_nxt;
      best_idx_r   <= best_idx_nxt;
      best_addr_r  <= best_addr_nxt;
      best_size_r  <= best_size_nxt;
      tgt_idx_r    <= tgt_idx_nxt;
      tgt_addr_r   <= tgt_addr_nxt;
      tgt_size_r   <= tgt_size_nxt;
      carry_r      <= carry_nxt;
      grow_r       <= grow_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // checks
  `BFA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
  `BFA_ASSERT(a_result_after_work, out_valid |-> $past(busy), "result without a request in work")
  `BFA_ASSERT(a_error_addr_zero, (out_valid && out_res.status != ST_OK) |-> out_res.data_addr == '0, "error result carries an address")
  `BFA_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid, "result strobe right after reset")

endmodule

// ----- tb/bfa_alloc_checker.sv -----
// Checker for the best-fit block allocator: watches all channels, predicts and compares
`timescale 1ns / 1ps
module bfa_alloc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  bfa_pkg::req_t                  in_req,
  input  logic                           out_valid,
  input  bfa_pkg::res_t                  out_res,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending
);
  import bfa_pkg::*;

  localparam longint ADDR_SPACE_MAX = (64'd1 << ADDR_BITS) - 1;

  // shadow block table and heap state
  logic [ADDR_BITS-1:0] tbl_addr [MAX_BLOCKS];
  logic [SIZE_W-1:0]    tbl_size [MAX_BLOCKS];
  logic                 tbl_busy [MAX_BLOCKS];
  int                   tbl_count;
  longint               heap_top;

  // shadow configuration
  longint hdr_len;
  longint page_len;
  longint limit_end;

  res_t expected_results[$];

  function automatic res_t make_res(logic [1:0] st, longint addr);
    res_t r;
    r.status    = st;
    r.data_addr = addr[23:0];
    return r;
  endfunction

  // open a slot at pos, shift the tail up, and place an unused block there
  function automatic void insert_entry(int pos, longint addr, longint size);
    for (int k = tbl_count; k > pos; k--) begin
      tbl_addr[k] = tbl_addr[k-1];
      tbl_size[k] = tbl_size[k-1];
      tbl_busy[k] = tbl_busy[k-1];
    end
    tbl_addr[pos] = addr[ADDR_BITS-1:0];
    tbl_size[pos] = size[SIZE_W-1:0];
    tbl_busy[pos] = 1'b0;
    tbl_count++;
  endfunction

  function automatic res_t predict_alloc_result(req_t rq);
    longint size;
    longint pg;
    longint grow;
    longint new_end;
    int     best;
    bit     found;
    size  = rq.req_size;
    best  = 0;
    found = 0;
    // free: first entry with a matching data address
    if (rq.req_type == REQ_FREE) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_addr[i] == rq.free_addr) begin
          tbl_busy[i] = 1'b0;
          return make_res(ST_OK, 0);
        end
      end
      return make_res(ST_NOT_FOUND, 0);
    end
    // exact-size hit
    for (int i = 0; i < tbl_count; i++) begin
      if (!tbl_busy[i] && tbl_size[i] == size) begin
        tbl_busy[i] = 1'b1;
        return make_res(ST_OK, tbl_addr[i]);
      end
    end
    // best fit that leaves room for a header
    for (int i = 0; i < tbl_count; i++) begin
      if (!tbl_busy[i] && size + hdr_len < tbl_size[i] &&
          (!found || tbl_size[i] < tbl_size[best])) begin
        best  = i;
        found = 1;
      end
    end
    if (!found) begin
      pg = (page_len == 0) ? 1 : page_len;
      if (tbl_count + 2 > MAX_BLOCKS) return make_res(ST_TBL_FULL, 0);
      grow    = ((2 * hdr_len + size) / pg + 1) * pg;
      new_end = heap_top + grow;
      if (new_end > limit_end || new_end > ADDR_SPACE_MAX) return make_res(ST_OUT_HEAP, 0);
      insert_entry(tbl_count, heap_top + hdr_len, grow - hdr_len);
      heap_top = new_end;
      best     = tbl_count - 1;
    end else if (tbl_count + 1 > MAX_BLOCKS) begin
      return make_res(ST_TBL_FULL, 0);
    end
    // split off the remainder right after the chosen block
    insert_entry(best + 1, longint'(tbl_addr[best]) + size + hdr_len,
                 longint'(tbl_size[best]) - size - hdr_len);
    tbl_size[best] = size[SIZE_W-1:0];
    tbl_busy[best] = 1'b1;
    return make_res(ST_OK, tbl_addr[best]);
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      tbl_count  <= 0;
      heap_top   <= 0;
      hdr_len    <= 32;
      page_len   <= 4096;
      limit_end  <= 24'hFFFFFF;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      // configuration transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEADER: hdr_len   = cfg_wdata[HDR_W-1:0];
          CFG_PAGE:   page_len  = cfg_wdata[PAGE_W-1:0];
          CFG_LIMIT:  limit_end = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      // result transfer: compare with the oldest expectation
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result status=%0d data_addr=%h", out_res.status, out_res.data_addr);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_res.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_res.status);
            fail_count++;
          end
          if (out_res.data_addr !== want.data_addr) begin
            $error("data_addr expected %h actual %h", want.data_addr, out_res.data_addr);
            fail_count++;
          end
        end
      end
      // request transfer
      if (start && !busy) expected_results.push_back(predict_alloc_result(in_req));
    end
  end
endmodule

// ----- tb/best_fit_block_allocator_unit_tb.sv -----
// Testbench top for the best-fit block allocator: stimulus, configuration phases, verdict
`timescale 1ns / 1ps
module best_fit_block_allocator_unit_tb;
  import bfa_pkg::*;

  localparam int DRAIN_CYCLES = 200;
  localparam int WATCHDOG_MAX = 20000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  req_t                  in_req;
  logic                  out_valid;
  res_t                  out_res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    quiet_cycles;
  int                    idle_pct;

  logic [23:0] live_addrs[$];
  logic [23:0] seen_sizes[$];

  best_fit_block_allocator_unit u_top (.*);

  bfa_alloc_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // collect returned addresses to aim frees at live blocks
  always @(posedge clk) begin
    if (out_valid && out_res.status == ST_OK) begin
      live_addrs.push_back(out_res.data_addr);
      if (live_addrs.size() > 200) void'(live_addrs.pop_front());
    end
  end

  // watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // hold start low and wait until every result is back, then let the block settle
  task automatic drain_block();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // present one register write and hold it until the transfer; valid stays high
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(int hdr, int page, int limit);
    drain_block();
    write_reg(CFG_HEADER, CFG_DATA_W'(hdr));
    write_reg(CFG_PAGE, CFG_DATA_W'(page));
    write_reg(CFG_LIMIT, CFG_DATA_W'(limit));
    cfg_valid <= 1'b0;
  endtask

  // present one request and hold it until the transfer
  task automatic issue(logic kind, logic [23:0] size, logic [23:0] addr);
    int gap;
    req_t rq;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 300);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rq.req_type  = kind;
    rq.req_size  = size;
    rq.free_addr = addr;
    start  <= 1'b1;
    in_req <= rq;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_item();
    int pick;
    logic [23:0] sz;
    pick = $urandom_range(99);
    if (pick < 30 && live_addrs.size() > 0) begin
      issue(REQ_FREE, 24'($urandom), live_addrs[$urandom_range(live_addrs.size() - 1)]);
    end else if (pick < 36) begin
      issue(REQ_FREE, 24'($urandom), 24'($urandom));
    end else if (pick < 40) begin
      issue(REQ_ALLOC, 24'($urandom), 24'($urandom));
    end else if (pick < 55 && seen_sizes.size() > 0) begin
      issue(REQ_ALLOC, seen_sizes[$urandom_range(seen_sizes.size() - 1)], 24'($urandom));
    end else begin
      sz = ($urandom_range(3) == 0) ? 24'($urandom_range(64)) : 24'($urandom_range(3000));
      seen_sizes.push_back(sz);
      if (seen_sizes.size() > 40) void'(seen_sizes.pop_front());
      issue(REQ_ALLOC, sz, 24'($urandom));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HEADER;
    cfg_wdata = '0;
    idle_pct  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small heap limit to reach heap exhaustion early
    set_config(32, 4096, 20000);
    issue(REQ_FREE, 24'hFFFFFF, 24'h000000);
    issue(REQ_FREE, 24'h000000, 24'hFFFFFF);
    issue(REQ_ALLOC, 24'd0, 24'hFFFFFF);
    issue(REQ_ALLOC, 24'd100, 24'd0);
    issue(REQ_FREE, 24'd0, 24'd32);
    issue(REQ_FREE, 24'd0, 24'd32);
    issue(REQ_ALLOC, 24'd0, 24'd0);
    issue(REQ_ALLOC, 24'hFFFFFF, 24'd0);
    issue(REQ_ALLOC, 24'd9000, 24'd0);
    issue(REQ_ALLOC, 24'd9000, 24'd0);
    for (int i = 0; i < 12; i++) issue(REQ_ALLOC, 24'(i), 24'd0);
    // zero header and zero page: shared data addresses
    set_config(0, 0, 24'hFFFFFF);
    issue(REQ_ALLOC, 24'd0, 24'd0);
    issue(REQ_ALLOC, 24'd0, 24'd0);
    issue(REQ_FREE, 24'd0, 24'd32);
    // pause until all results are in
    drain_block();

    // random phases across settings and idle mixes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(1, 1, 24'hFFFFFF);
        1: set_config(4096, 65536, 24'hFFFFFF);
        2: set_config(16, 256, 24'hFFFFFF);
        3: set_config(8191, 131071, 24'hFFFFFF);
        4: set_config(32, 4096, 0);
        default: set_config(8, 64, 24'hFFFFFF);
      endcase
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 78;
        default: idle_pct = 16;
      endcase
      for (int i = 0; i < 215; i++) random_item();
    end

    drain_block();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+design
design/bfa_pkg.sv
design/bfa_cell.sv
design/bfa_div.sv
design/best_fit_block_allocator_unit.sv
tb/bfa_alloc_checker.sv
tb/best_fit_block_allocator_unit_tb.sv
